// ===== hw/rtl/ppa_pkg.sv =====
package ppa_pkg;

    // Fixed field widths of the ports
    localparam int PAGE_W    = 14;
    localparam int CFG_W     = 15;
    localparam int REF_OUT_W = 16;
    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 2;

    // Pages addressable through a page field
    localparam int INDEX_SPAN = 16384;

    // Defaults for the top-level parameters
    localparam int NUM_PAGES_DEF  = 16384;
    localparam int COUNT_BITS_DEF = 16;

    // Register reset values
    localparam logic [CFG_W-1:0] TOTAL_PAGES_RST    = 15'd16384;
    localparam logic [CFG_W-1:0] RESERVED_PAGES_RST = 15'd0;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_INIT   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_INCREF = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DECREF = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_MEM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_COUNT  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ERROR  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_TOTAL_PAGES    = 1'b0;
    localparam logic CFG_RESERVED_PAGES = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_EXEC
    } state_t;

endpackage

// ===== hw/rtl/physical_page_allocator.sv =====
// Page frame allocator with a LIFO free list and one reference count per page.
// Each operation (alloc, free, incref, decref) reads the link memory and the count
// memory when it is accepted, then modifies and writes them back and loads the
// result register. Init sweeps every page entry at one per cycle. After reset the
// block runs a clearing pass over the link memory before s_tready first rises;
// register writes are taken during that pass. A waiting result holds the next
// operation in write-back until that result is taken.
module physical_page_allocator
    import ppa_pkg::*;
#(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [13:0] page_index, [15:14] zero
    input  logic [FUNC_W-1:0]    s_tuser,   // [2:0] func
    // Result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [13:0] page_out, [29:14] ref_after,
                                            // [30] released, [31] zero
    output logic [STATUS_W-1:0]  m_tuser,   // [1:0] status
    // Register write port
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int AW  = $clog2(NUM_PAGES);
    localparam int CW  = COUNT_BITS;
    localparam int LW  = PAGE_W + 1;
    localparam int CAP = (NUM_PAGES < INDEX_SPAN) ? NUM_PAGES : INDEX_SPAN;
    localparam logic [CW-1:0] COUNT_MAX = '1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PAGES - 1);

    // Control and configuration registers
    state_t               state_reg, state_next;
    logic [AW-1:0]        sweep_reg, sweep_next;
    logic [CFG_W-1:0]     total_pages_reg, reserved_pages_reg;
    logic                 head_valid_reg, head_valid_next;
    logic [PAGE_W-1:0]    free_head_reg, free_head_next;

    // Captured operation
    logic [FUNC_W-1:0]    func_reg;
    logic [PAGE_W-1:0]    page_reg;
    logic [AW-1:0]        addr_reg;

    // Result register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [PAGE_W-1:0]    page_out_reg, page_out_next;
    logic [REF_OUT_W-1:0] ref_after_reg, ref_after_next;
    logic                 released_reg, released_next;

    // Memory ports
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 link_we, cnt_we;
    logic [LW-1:0]        link_wdata, link_rdata;
    logic [CW-1:0]        cnt_wdata, cnt_rdata;

    // Derived values
    logic                 accept;
    logic                 out_free;
    logic [CFG_W-1:0]     limit, res;
    logic [31:0]          in_page_w, head_w, page_w, sweep_w, limit_w, res_w;
    logic                 in_range;
    logic [31:0]          ref_w;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Effective page count and reserved boundary
    assign limit = (32'(total_pages_reg) > 32'(CAP)) ? CFG_W'(CAP) : total_pages_reg;
    assign res   = (reserved_pages_reg > limit) ? limit : reserved_pages_reg;

    assign in_page_w = 32'(s_tdata[PAGE_W-1:0]);
    assign head_w    = 32'(free_head_reg);
    assign page_w    = 32'(page_reg);
    assign sweep_w   = 32'(sweep_reg);
    assign limit_w   = 32'(limit);
    assign res_w     = 32'(res);
    assign in_range  = page_w < limit_w;

    // Link memory: {on free list, next link}
    ppa_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_PAGES)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (wr_addr),
        .wdata (link_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (link_rdata)
    );

    // Reference count memory
    ppa_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_PAGES)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (wr_addr),
        .wdata (cnt_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (cnt_rdata)
    );

    // Sequencer state and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_CLEAR;
            sweep_reg          <= '0;
            head_valid_reg     <= 1'b0;
            m_tvalid_reg       <= 1'b0;
            total_pages_reg    <= TOTAL_PAGES_RST;
            reserved_pages_reg <= RESERVED_PAGES_RST;
        end else begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            head_valid_reg <= head_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_TOTAL_PAGES:    total_pages_reg    <= cfg_wdata;
                    CFG_RESERVED_PAGES: reserved_pages_reg <= cfg_wdata;
                    default:            total_pages_reg    <= total_pages_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        free_head_reg <= free_head_next;
        status_reg    <= status_next;
        page_out_reg  <= page_out_next;
        ref_after_reg <= ref_after_next;
        released_reg  <= released_next;
        if (accept) begin
            func_reg <= s_tuser;
            page_reg <= s_tdata[PAGE_W-1:0];
            addr_reg <= rd_addr;
        end
    end

    // Next state, memory accesses and results
    always_comb begin
        logic [CW-1:0]     cnt_new;
        logic              show;
        logic              push;
        logic [PAGE_W-1:0] link_next;
        logic              link_on;

        state_next      = state_reg;
        sweep_next      = sweep_reg;
        head_valid_next = head_valid_reg;
        free_head_next  = free_head_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        status_next     = status_reg;
        page_out_next   = page_out_reg;
        ref_after_next  = ref_after_reg;
        released_next   = released_reg;
        s_tready        = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = (s_tuser == FUNC_ALLOC) ? head_w[AW-1:0] : in_page_w[AW-1:0];
        wr_addr         = addr_reg;
        link_we         = 1'b0;
        link_wdata      = '0;
        cnt_we          = 1'b0;
        cnt_wdata       = cnt_rdata;
        cnt_new         = cnt_rdata;
        show            = in_range;
        push            = 1'b0;
        link_on         = link_rdata[LW-1];
        link_next       = link_rdata[PAGE_W-1:0];
        ref_w           = '0;

        unique case (state_reg)
            // Clear membership bits after reset
            ST_CLEAR: begin
                wr_addr    = sweep_reg;
                link_we    = 1'b1;
                link_wdata = '0;
                if (sweep_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                    sweep_next = '0;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            // Take an operation and issue the reads
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    rd_en      = 1'b1;
                    sweep_next = '0;
                    state_next = (s_tuser == FUNC_INIT) ? ST_INIT : ST_EXEC;
                end
            end

            // Rebuild counts and the free list, one page a cycle
            ST_INIT: begin
                wr_addr = sweep_reg;
                link_we = 1'b1;
                cnt_we  = sweep_w < limit_w;
                cnt_wdata = (sweep_w < res_w) ? CW'(1) : '0;
                if (sweep_w >= res_w && sweep_w < limit_w) begin
                    link_wdata = (sweep_w == res_w) ? {1'b1, PAGE_W'(sweep_w)}
                                                    : {1'b1, PAGE_W'(sweep_w - 32'd1)};
                end else begin
                    link_wdata = '0;
                end
                if (sweep_reg == LAST_ADDR) begin
                    state_next = ST_EXEC;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            // Modify, write back, load the result
            ST_EXEC: begin
                status_next   = STATUS_OK;
                page_out_next = page_reg;
                released_next = 1'b0;
                unique case (func_reg)
                    FUNC_INIT: begin
                        cnt_new = (page_w < res_w) ? CW'(1) : '0;
                        head_valid_next = res < limit;
                        free_head_next  = PAGE_W'(limit_w - 32'd1);
                    end
                    FUNC_ALLOC: begin
                        if (!head_valid_reg) begin
                            status_next = STATUS_NO_MEM;
                            show        = 1'b0;
                        end else begin
                            link_we       = 1'b1;
                            link_wdata    = {1'b0, link_next};
                            page_out_next = free_head_reg;
                            show          = 1'b1;
                            if (link_next == free_head_reg) begin
                                head_valid_next = 1'b0;
                            end else begin
                                free_head_next = link_next;
                            end
                        end
                    end
                    FUNC_FREE: begin
                        priority if (!in_range || link_on) begin
                            status_next = STATUS_ERROR;
                        end else if (cnt_rdata != '0) begin
                            status_next = STATUS_COUNT;
                        end else begin
                            push = 1'b1;
                        end
                    end
                    FUNC_INCREF: begin
                        priority if (!in_range || cnt_rdata == COUNT_MAX) begin
                            status_next = STATUS_ERROR;
                        end else begin
                            cnt_new = cnt_rdata + 1'b1;
                            cnt_we  = 1'b1;
                        end
                    end
                    FUNC_DECREF: begin
                        priority if (!in_range) begin
                            status_next = STATUS_ERROR;
                        end else if (cnt_rdata == '0) begin
                            status_next = STATUS_COUNT;
                        end else begin
                            cnt_new = cnt_rdata - 1'b1;
                            cnt_we  = 1'b1;
                            if (cnt_new == '0) begin
                                if (link_on) begin
                                    status_next = STATUS_ERROR;
                                end else begin
                                    push          = 1'b1;
                                    released_next = 1'b1;
                                end
                            end
                        end
                    end
                    default: begin
                        status_next = STATUS_ERROR;
                    end
                endcase

                // Push the page onto the list head; the first entry links to itself
                if (push) begin
                    link_we         = 1'b1;
                    link_wdata      = {1'b1, head_valid_reg ? free_head_reg : page_reg};
                    free_head_next  = page_reg;
                    head_valid_next = 1'b1;
                end
                cnt_wdata      = cnt_new;
                ref_w          = show ? 32'(cnt_new) : '0;
                ref_after_next = ref_w[REF_OUT_W-1:0];

                // Hold everything while the previous result waits
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    link_we         = 1'b0;
                    cnt_we          = 1'b0;
                    head_valid_next = head_valid_reg;
                    free_head_next  = free_head_reg;
                    status_next     = status_reg;
                    page_out_next   = page_out_reg;
                    ref_after_next  = ref_after_reg;
                    released_next   = released_reg;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {1'b0, released_reg, ref_after_reg, page_out_reg};

`ifndef SYNTHESIS
    // An accepted operation always moves the sequencer out of idle
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_EXEC || state_reg == ST_INIT))
        else $error("accepted operation did not start");

    // A new result only comes from the write-back cycle
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_EXEC)
        else $error("result loaded outside write-back");

    // A released page is always a successful operation
    a_released_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && released_reg) |-> status_reg == STATUS_OK)
        else $error("release flagged with error status");

    // No item is taken during the clearing pass or a sweep
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR || state_reg == ST_INIT) |-> !s_tready)
        else $error("ready raised while sweeping");
`endif

endmodule

// ===== hw/rtl/ppa_ram.sv =====
module ppa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== tb/sv/physical_page_allocator_check.sv =====
module physical_page_allocator_check
    import ppa_pkg::*;
#(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [13:0] page_index, [15:14] zero
    input  logic [FUNC_W-1:0]    s_tuser,   // [2:0] func
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [31:0]          m_tdata,   // [13:0] page_out, [29:14] ref_after,
                                            // [30] released, [31] zero
    input  logic [STATUS_W-1:0]  m_tuser,   // [1:0] status
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   fail_count,
    output int                   results_pending
);

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [PAGE_W-1:0]    page;
        logic [REF_OUT_W-1:0] ref_after;
        logic                 released;
    } page_result_t;

    localparam logic [31:0] REF_LIMIT = 32'hFFFF_FFFF >> (32 - COUNT_BITS);

    // Shadow copy of the allocator state
    logic [31:0]      link_mem  [NUM_PAGES];
    logic [31:0]      page_refs [NUM_PAGES];
    bit               listed    [NUM_PAGES];
    logic [31:0]      head;
    bit               head_ok;
    logic [CFG_W-1:0] total_pages;
    logic [CFG_W-1:0] reserved_pages;

    page_result_t results_due[$];

    function automatic int unsigned page_span();
        int unsigned n;
        n = 32'(total_pages);
        if (n > NUM_PAGES) n = NUM_PAGES;
        if (n > INDEX_SPAN) n = INDEX_SPAN;
        return n;
    endfunction

    // Push onto the LIFO list; the first entry links to itself as the tail
    function automatic void push_free(input int unsigned p);
        link_mem[p] = head_ok ? head : p;
        listed[p]   = 1'b1;
        head        = p;
        head_ok     = 1'b1;
    endfunction

    function automatic page_result_t apply_page_op(input logic [FUNC_W-1:0] op,
                                                   input logic [PAGE_W-1:0] pg);
        int unsigned  lim;
        int unsigned  res_top;
        logic [31:0]  nxt;
        bit           in_range;
        bit           show;
        page_result_t r;
        lim         = page_span();
        in_range    = (32'(pg) < lim);
        show        = in_range;
        r.status    = STATUS_OK;
        r.page      = pg;
        r.ref_after = '0;
        r.released  = 1'b0;
        if (op == FUNC_INIT) begin
            res_top = (32'(reserved_pages) < lim) ? 32'(reserved_pages) : lim;
            for (int i = 0; i < NUM_PAGES; i++) listed[i] = 1'b0;
            head_ok = 1'b0;
            head    = '0;
            for (int i = 0; i < res_top; i++) page_refs[i] = 1;
            for (int i = res_top; i < lim; i++) begin
                page_refs[i] = 0;
                push_free(i);
            end
        end else if (op == FUNC_ALLOC) begin
            if (!head_ok) begin
                r.status = STATUS_NO_MEM;
                show     = 1'b0;
            end else begin
                nxt          = link_mem[head];
                listed[head] = 1'b0;
                r.page       = head[PAGE_W-1:0];
                if (nxt == head) head_ok = 1'b0;
                else head = nxt;
                show = 1'b1;
            end
        end else if (op > FUNC_DECREF || !in_range) begin
            r.status = STATUS_ERROR;
        end else if (op == FUNC_FREE) begin
            if (listed[pg]) r.status = STATUS_ERROR;
            else if (page_refs[pg] != 0) r.status = STATUS_COUNT;
            else push_free(pg);
        end else if (op == FUNC_INCREF) begin
            if (page_refs[pg] >= REF_LIMIT) r.status = STATUS_ERROR;
            else page_refs[pg] = page_refs[pg] + 1;
        end else begin
            if (page_refs[pg] == 0) begin
                r.status = STATUS_COUNT;
            end else begin
                page_refs[pg] = page_refs[pg] - 1;
                if (page_refs[pg] == 0) begin
                    // a page still on the list is not pushed twice
                    if (listed[pg]) begin
                        r.status = STATUS_ERROR;
                    end else begin
                        push_free(pg);
                        r.released = 1'b1;
                    end
                end
            end
        end
        if (show) r.ref_after = page_refs[r.page][REF_OUT_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        page_result_t exp_r;
        page_result_t got_r;
        if (!aresetn) begin
            total_pages    = TOTAL_PAGES_RST;
            reserved_pages = RESERVED_PAGES_RST;
            head           = '0;
            head_ok        = 1'b0;
            for (int i = 0; i < NUM_PAGES; i++) begin
                link_mem[i]  = '0;
                page_refs[i] = '0;
                listed[i]    = 1'b0;
            end
            results_due.delete();
            fail_count      = 0;
            results_pending = 0;
        end else begin
            // Track register writes
            if (cfg_we) begin
                if (cfg_addr == CFG_TOTAL_PAGES) total_pages = cfg_wdata;
                else reserved_pages = cfg_wdata;
            end
            // Compare each result transfer with the oldest prediction
            if (m_tvalid && m_tready) begin
                got_r.status    = m_tuser;
                got_r.page      = m_tdata[PAGE_W-1:0];
                got_r.ref_after = m_tdata[PAGE_W +: REF_OUT_W];
                got_r.released  = m_tdata[PAGE_W + REF_OUT_W];
                if (results_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: status %0d page %0d ref %0d released %0b",
                                 got_r.status, got_r.page, got_r.ref_after, got_r.released);
                    fail_count++;
                end else begin
                    exp_r = results_due.pop_front();
                    if (got_r !== exp_r) begin
                        if (fail_count < 10)
                            $display({"result mismatch: expected status %0d page %0d ref %0d ",
                                      "released %0b, got status %0d page %0d ref %0d released %0b"},
                                     exp_r.status, exp_r.page, exp_r.ref_after, exp_r.released,
                                     got_r.status, got_r.page, got_r.ref_after, got_r.released);
                        fail_count++;
                    end
                end
            end
            // Predict the result of each accepted operation
            if (s_tvalid && s_tready)
                results_due.push_back(apply_page_op(s_tuser, s_tdata[PAGE_W-1:0]));
            results_pending = results_due.size();
        end
    end

endmodule

// ===== tb/sv/physical_page_allocator_tb.sv =====
module physical_page_allocator_tb;
    import ppa_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 4_000_000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          PHASES       = 10;
    localparam int          PHASE_OPS    = 60;

    // Page count, reserved boundary and whether init opens each random phase
    localparam int PH_TOTAL [PHASES] = '{16, 1, 33, 9, 2, 5, 16384, 16384, 16384, 12};
    localparam int PH_RSV   [PHASES] = '{0, 0, 4, 4, 1, 12, 0, 16380, 16384, 3};
    localparam bit PH_INIT  [PHASES] = '{1, 1, 1, 0, 1, 1, 1, 1, 1, 1};

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic [15:0]         s_tdata   = '0;
    logic [FUNC_W-1:0]   s_tuser   = FUNC_INIT;
    logic                m_tready  = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_addr  = CFG_TOTAL_PAGES;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tready;
    logic                m_tvalid;
    logic [31:0]         m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    int          fail_count;
    int          results_pending;
    int unsigned cycle_count  = 0;
    int unsigned cur_total    = TOTAL_PAGES_RST;
    bit          tx_idle      = 1'b1;
    bit          rx_idle      = 1'b1;
    bit          hold_req     = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    physical_page_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    physical_page_allocator_check ppa_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("physical_page_allocator verification failed");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Offer one operation and hold it until the transfer completes
    task automatic issue(input logic [FUNC_W-1:0] op, input logic [PAGE_W-1:0] pg);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {2'b00, pg};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Drop valid and wait for every predicted result to come back
    task automatic settle();
        s_tvalid = 1'b0;
        while (results_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic configure(input int unsigned total, input int unsigned reserved);
        settle();
        cfg_we    = 1'b1;
        cfg_addr  = CFG_TOTAL_PAGES;
        cfg_wdata = total[CFG_W-1:0];
        @(negedge aclk);
        cfg_addr  = CFG_RESERVED_PAGES;
        cfg_wdata = reserved[CFG_W-1:0];
        @(negedge aclk);
        cfg_we    = 1'b0;
        cur_total = total;
    endtask

    // Mostly in-range pages near the head of the list, some anywhere
    task automatic random_op();
        int unsigned         r;
        int unsigned         lim;
        logic [FUNC_W-1:0]   op;
        logic [PAGE_W-1:0]   pg;
        lim = cur_total;
        if (lim > NUM_PAGES_DEF) lim = NUM_PAGES_DEF;
        if (lim > INDEX_SPAN) lim = INDEX_SPAN;
        r = $urandom_range(0, 99);
        if (r < 30) op = FUNC_ALLOC;
        else if (r < 45) op = FUNC_FREE;
        else if (r < 65) op = FUNC_INCREF;
        else if (r < 88) op = FUNC_DECREF;
        else if (r < 89) op = FUNC_INIT;
        else op = FUNC_DECREF + FUNC_W'($urandom_range(1, 3));
        if ($urandom_range(0, 6) == 0) pg = PAGE_W'($urandom_range(0, INDEX_SPAN - 1));
        else if (lim <= 64 || $urandom_range(0, 3) == 0) pg = PAGE_W'($urandom_range(0, lim - 1));
        else pg = PAGE_W'(lim - 1 - $urandom_range(0, 15));
        issue(op, pg);
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Nothing on the list before the first init
        issue(FUNC_ALLOC, 14'd0);

        // Eight pages, three reserved: the list holds 7 down to 3
        configure(8, 3);
        issue(FUNC_INIT, 14'd2);
        issue(FUNC_ALLOC, 14'd0);
        issue(FUNC_INCREF, 14'd7);
        issue(FUNC_INCREF, 14'd7);
        issue(FUNC_FREE, 14'd7);         // count still held
        issue(FUNC_DECREF, 14'd7);
        issue(FUNC_DECREF, 14'd7);       // drops to zero, page goes back
        issue(FUNC_FREE, 14'd7);         // double free
        issue(FUNC_DECREF, 14'd7);       // count already zero
        issue(FUNC_INCREF, 14'd6);       // page on the list stays there
        issue(FUNC_DECREF, 14'd6);       // zero while listed
        issue(FUNC_ALLOC, 14'd0);
        issue(FUNC_ALLOC, 14'd0);
        issue(FUNC_INCREF, 14'd2);
        issue(FUNC_DECREF, 14'd0);       // reserved page released
        issue(FUNC_FREE, 14'd16383);     // out of range
        issue(FUNC_INCREF, 14'd8);
        issue(FUNC_DECREF + 3'd1, 14'd1);
        issue(FUNC_DECREF + 3'd2, 14'd9);
        issue(FUNC_DECREF + 3'd3, 14'd16383);
        repeat (5) issue(FUNC_ALLOC, 14'd0);
        issue(FUNC_FREE, 14'd7);

        // Run one count up at full speed
        settle();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (20) issue(FUNC_INCREF, 14'd1);
        issue(FUNC_INCREF, 14'd1);
        issue(FUNC_DECREF, 14'd1);
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        // Random phases over several page counts and reserved boundaries
        for (int ph = 0; ph < PHASES; ph++) begin
            configure(PH_TOTAL[ph], PH_RSV[ph]);
            if (ph == PHASES - 1) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            if (PH_INIT[ph]) issue(FUNC_INIT, PAGE_W'($urandom_range(0, INDEX_SPAN - 1)));
            if (ph == 0) hold_req = 1'b1;
            repeat (PHASE_OPS) random_op();
        end

        settle();
        repeat (20) @(negedge aclk);
        if (fail_count == 0) begin
            $display("physical_page_allocator verification clean");
        end else begin
            $display("physical_page_allocator verification failed");
        end
        $finish;
    end

endmodule
